FILE: src/tcq_pkg.sv
// Shared types and codes for the two-class task queue.
// No dependencies; imported by the top level, tcq_ctrl and tcq_dpath.
package tcq_pkg;

	// Request kinds carried in the low bits of the input tuser.
	localparam logic [1:0] REQ_PUSH    = 2'd0;
	localparam logic [1:0] REQ_POP     = 2'd1;
	localparam logic [1:0] REQ_PROMOTE = 2'd2;

	// Result status codes carried in the low bits of the output tuser.
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_NONE  = 2'd3;

	// Fixed field widths of the stream words.
	localparam int FIELD_TASK_W  = 50;
	localparam int FIELD_LEVEL_W = 4;
	localparam int IN_DATA_W     = 56;
	localparam int OUT_DATA_W    = 64;
	localparam int USER_W        = 3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} tcq_cmd_t;

endpackage

FILE: src/two_class_queue_with_promotion.sv
// Top level of the two-class task queue with promotion.
// Depends on tcq_pkg, tcq_ctrl, tcq_dpath and tcq_ram.
//
// Usage: each word on the slave stream is one request. s_tuser[1:0] is the
// request kind (push, pop, promote; the unused code is ignored and reports
// done), s_tuser[2] selects the priority class for a push, and s_tdata[49:0]
// carries the task word for a push. Every request yields exactly one word on
// the master stream holding the status, the popped task and its class, and
// the levels of both FIFOs after the request.
// Pops always drain the priority FIFO first. A promote moves the oldest
// normal task to the tail of the priority FIFO. Both FIFOs share CAPACITY
// entries; a push is refused once the combined occupancy reaches it.
// Timing: a request is accepted in the idle state and the stores are read at
// that edge; the execute state then commits the update and loads the output
// register, which then holds the valid result word. A new request is taken
// only after the last one has committed, set by the registered read of the
// task stores.
// The output register lets the block accept the next request while a result
// waits; if the receiver stalls, that request holds in its execute cycle
// until the output register frees up. Reset empties both FIFOs and drops any
// pending output word; the stores themselves are not cleared.
module two_class_queue_with_promotion
	import tcq_pkg::*;
#(
	parameter int CAPACITY   = 8,
	parameter int TASK_WIDTH = 50
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // push_task[49:0], zero pad[55:50]
	input  logic [USER_W-1:0]     s_tuser,  // req_type[1:0], push_priority[2]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // pop_task[49:0], normal_level[53:50],
	                                        // priority_level[57:54], zero pad[63:58]
	output logic [USER_W-1:0]     m_tuser   // status[1:0], pop_was_priority[2]
);

	// Commands from the sequencer to the queue datapath.
	tcq_cmd_t cmd;

	tcq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	tcq_dpath #(
		.CAPACITY   (CAPACITY),
		.TASK_WIDTH (TASK_WIDTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

FILE: src/tcq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcq_ram #(
	parameter int WIDTH = 50,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/tcq_ctrl.sv
// Controller for the two-class task queue: request sequencing and output valid.
// Depends on tcq_pkg.
module tcq_ctrl
	import tcq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output tcq_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   commit;

	assign s_tready    = (state_q == S_IDLE);
	assign commit      = (state_q == S_EXEC) && (!out_valid_q || m_tready);
	assign cmd.capture = s_tvalid && s_tready;
	assign cmd.commit  = commit;
	assign m_tvalid    = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (commit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_commit_only_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (state_q == S_EXEC))
		else $error("commit issued outside the execute state");
	a_valid_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.commit))
		else $error("output word appeared without a commit");
	a_no_capture_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> !cmd.capture)
		else $error("request captured while one is in progress");
`endif

endmodule

FILE: src/tcq_dpath.sv
// Datapath for the two-class task queue: request latch, FIFO pointers and
// occupancies, the two task stores and the output register. Depends on
// tcq_pkg and tcq_ram.
module tcq_dpath
	import tcq_pkg::*;
#(
	parameter int CAPACITY   = 8,
	parameter int TASK_WIDTH = 50
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcq_cmd_t              cmd,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [USER_W-1:0]     s_tuser,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [USER_W-1:0]     m_tuser
);

	localparam int PW = $clog2(CAPACITY);
	localparam int OW = $clog2(CAPACITY + 1);

	// Latched request.
	logic [1:0]            req_s1;
	logic                  prio_s1;
	logic [TASK_WIDTH-1:0] task_s1;

	// FIFO control state.
	logic [PW-1:0] n_rd_ptr_q, n_wr_ptr_q, p_rd_ptr_q, p_wr_ptr_q;
	logic [OW-1:0] n_occ_q, p_occ_q, n_occ_d, p_occ_d;

	// Store ports.
	logic                  n_wr_en, p_wr_en;
	logic [TASK_WIDTH-1:0] n_rd_data, p_rd_data, p_wr_data;
	logic                  n_rd_adv, p_rd_adv;

	// Result.
	logic [1:0]            status_d;
	logic [TASK_WIDTH-1:0] popped_d;
	logic                  from_p_d;
	logic [OW:0]           occ_sum;
	logic                  full;

	// Output register.
	logic [1:0]               status_q;
	logic [FIELD_TASK_W-1:0]  pop_task_q;
	logic                     from_p_q;
	logic [FIELD_LEVEL_W-1:0] n_lvl_q, p_lvl_q;

	// Width adapters between the fixed field widths and the store width.
	logic [TASK_WIDTH+FIELD_TASK_W-1:0]  push_ext, pop_ext;
	logic [OW+FIELD_LEVEL_W-1:0]         n_lvl_ext, p_lvl_ext;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(CAPACITY - 1)) begin
			r = '0;
		end else begin
			r = p + PW'(1);
		end
		return r;
	endfunction

	assign push_ext = {{TASK_WIDTH{1'b0}}, s_tdata[FIELD_TASK_W-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_s1  <= s_tuser[1:0];
			prio_s1 <= s_tuser[2];
			task_s1 <= push_ext[TASK_WIDTH-1:0];
		end
	end

	tcq_ram #(.WIDTH(TASK_WIDTH), .DEPTH(CAPACITY)) u_nrm_ram (
		.clk     (clk),
		.wr_en   (n_wr_en && cmd.commit),
		.wr_addr (n_wr_ptr_q),
		.wr_data (task_s1),
		.rd_addr (n_rd_ptr_q),
		.rd_data (n_rd_data)
	);

	tcq_ram #(.WIDTH(TASK_WIDTH), .DEPTH(CAPACITY)) u_pri_ram (
		.clk     (clk),
		.wr_en   (p_wr_en && cmd.commit),
		.wr_addr (p_wr_ptr_q),
		.wr_data (p_wr_data),
		.rd_addr (p_rd_ptr_q),
		.rd_data (p_rd_data)
	);

	assign occ_sum = {1'b0, n_occ_q} + {1'b0, p_occ_q};
	assign full    = (occ_sum >= (OW + 1)'(CAPACITY));

	always_comb begin
		n_wr_en   = 1'b0;
		p_wr_en   = 1'b0;
		p_wr_data = task_s1;
		n_rd_adv  = 1'b0;
		p_rd_adv  = 1'b0;
		status_d  = ST_DONE;
		popped_d  = '0;
		from_p_d  = 1'b0;
		n_occ_d   = n_occ_q;
		p_occ_d   = p_occ_q;
		case (req_s1)
			REQ_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (prio_s1) begin
					p_wr_en = 1'b1;
					p_occ_d = p_occ_q + OW'(1);
				end else begin
					n_wr_en = 1'b1;
					n_occ_d = n_occ_q + OW'(1);
				end
			end
			REQ_POP: begin
				if (p_occ_q != '0) begin
					popped_d = p_rd_data;
					from_p_d = 1'b1;
					p_rd_adv = 1'b1;
					p_occ_d  = p_occ_q - OW'(1);
				end else if (n_occ_q != '0) begin
					popped_d = n_rd_data;
					n_rd_adv = 1'b1;
					n_occ_d  = n_occ_q - OW'(1);
				end else begin
					status_d = ST_EMPTY;
				end
			end
			REQ_PROMOTE: begin
				if (n_occ_q != '0) begin
					n_rd_adv  = 1'b1;
					n_occ_d   = n_occ_q - OW'(1);
					p_wr_en   = 1'b1;
					p_wr_data = n_rd_data;
					p_occ_d   = p_occ_q + OW'(1);
				end else begin
					status_d = ST_NONE;
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_rd_ptr_q <= '0;
			n_wr_ptr_q <= '0;
			p_rd_ptr_q <= '0;
			p_wr_ptr_q <= '0;
			n_occ_q    <= '0;
			p_occ_q    <= '0;
		end else if (cmd.commit) begin
			if (n_rd_adv) begin
				n_rd_ptr_q <= ptr_next(n_rd_ptr_q);
			end
			if (n_wr_en) begin
				n_wr_ptr_q <= ptr_next(n_wr_ptr_q);
			end
			if (p_rd_adv) begin
				p_rd_ptr_q <= ptr_next(p_rd_ptr_q);
			end
			if (p_wr_en) begin
				p_wr_ptr_q <= ptr_next(p_wr_ptr_q);
			end
			n_occ_q <= n_occ_d;
			p_occ_q <= p_occ_d;
		end
	end

	assign pop_ext   = {{FIELD_TASK_W{1'b0}}, popped_d};
	assign n_lvl_ext = {{FIELD_LEVEL_W{1'b0}}, n_occ_d};
	assign p_lvl_ext = {{FIELD_LEVEL_W{1'b0}}, p_occ_d};

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q   <= status_d;
			pop_task_q <= pop_ext[FIELD_TASK_W-1:0];
			from_p_q   <= from_p_d;
			n_lvl_q    <= n_lvl_ext[FIELD_LEVEL_W-1:0];
			p_lvl_q    <= p_lvl_ext[FIELD_LEVEL_W-1:0];
		end
	end

	assign m_tdata = {6'd0, p_lvl_q, n_lvl_q, pop_task_q};
	assign m_tuser = {from_p_q, status_q};

`ifndef SYNTH
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_sum <= (OW + 1)'(CAPACITY))
		else $error("combined occupancy exceeds capacity");
	a_hold_without_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> ($stable(n_occ_q) && $stable(p_occ_q) &&
			$stable(n_rd_ptr_q) && $stable(p_wr_ptr_q)))
		else $error("queue state changed without a commit");
	a_promote_keeps_total: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && req_s1 == REQ_PROMOTE) |=> (occ_sum == $past(occ_sum)))
		else $error("promote changed the combined occupancy");
`endif

endmodule
